// File: sv/fadd_pkg.sv
// ----------------------------------------------------------------------------
// fadd_pkg: shared types and constants of the float32 add/subtract core
// Field widths, the front-to-back queue entry and the exponent constants.
// ----------------------------------------------------------------------------
package fadd_pkg;

  localparam int WordW   = 32;
  localparam int ExpW    = 8;
  localparam int FracW   = 23;
  localparam int MantW   = 24;
  localparam int QueueDepthDefault = 2;

  localparam logic [ExpW-1:0] ExpMax = 8'hFF;

  // Classified operand pair handed from the front part to the back part
  typedef struct packed {
    logic             bypass;     // result already known (zero operand)
    logic [WordW-1:0] bypass_val;
    logic             sign_big;
    logic             eff_sub;
    logic [ExpW-1:0]  e_big;
    logic [MantW-1:0] m_big;
    logic [MantW-1:0] m_small;    // already aligned
  } fadd_item_t;

endpackage

// File: sv/fadd_front.sv
// ----------------------------------------------------------------------------
// fadd_front: operand classify and align stage
// Applies the subtract sign flip, handles zero operands, orders operands by
// magnitude and aligns the smaller mantissa. Registered output.
// ----------------------------------------------------------------------------
module fadd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_beat,
  input  logic [fadd_pkg::WordW-1:0]        in_operand_a,
  input  logic [fadd_pkg::WordW-1:0]        in_operand_b,
  input  logic                              in_operation,
  output logic                              item_valid,
  output fadd_pkg::fadd_item_t              item
);

  logic [fadd_pkg::WordW-1:0]  b_fix;
  logic                        a_zero, b_zero, a_big;
  logic [fadd_pkg::WordW-1:0]  big, lesser;
  logic [fadd_pkg::ExpW-1:0]   diff;
  logic [fadd_pkg::MantW-1:0]  m_small_raw;
  fadd_pkg::fadd_item_t        item_nxt, item_r;
  logic                        valid_r;

  // classify and align
  always_comb begin
    b_fix  = {in_operand_b[31] ^ in_operation, in_operand_b[30:0]};
    a_zero = (in_operand_a[30:23] == '0);
    b_zero = (b_fix[30:23] == '0);
    a_big  = (in_operand_a[30:0] >= b_fix[30:0]);
    big    = a_big ? in_operand_a : b_fix;
    lesser = a_big ? b_fix : in_operand_a;
    diff   = big[30:23] - lesser[30:23];
    m_small_raw = {1'b1, lesser[22:0]};
    item_nxt.bypass     = a_zero || b_zero;
    item_nxt.bypass_val = (a_zero && b_zero) ? '0 : (a_zero ? b_fix : in_operand_a);
    item_nxt.sign_big   = big[31];
    item_nxt.eff_sub    = big[31] ^ lesser[31];
    item_nxt.e_big      = big[30:23];
    item_nxt.m_big      = {1'b1, big[22:0]};
    item_nxt.m_small    = (diff >= 8'd24) ? '0 : (m_small_raw >> diff[4:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_beat;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: sv/fadd_queue.sv
// ----------------------------------------------------------------------------
// fadd_queue: short FIFO between front and back parts
// Has no full flag and takes no stall from either side; depth is a parameter.
// ----------------------------------------------------------------------------
module fadd_queue #(
  parameter int Depth = fadd_pkg::QueueDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fadd_pkg::fadd_item_t push_item,
  input  logic                 pop,
  output logic                 not_empty,
  output fadd_pkg::fadd_item_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  fadd_pkg::fadd_item_t mem_r [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PtrW:0]   cnt_r, cnt_nxt;

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_r] <= push_item;
  end

  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

endmodule

// File: sv/fadd_back.sv
// ----------------------------------------------------------------------------
// fadd_back: add, normalize and pack stage
// Adds or subtracts aligned mantissas, finds the leading one, normalizes,
// truncates and packs with overflow and underflow saturation.
// ----------------------------------------------------------------------------
module fadd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  fadd_pkg::fadd_item_t        item,
  output logic                        out_valid,
  output logic [fadd_pkg::WordW-1:0]  out_result_bits
);

  logic [fadd_pkg::MantW:0]   r;
  logic [4:0]                 p;
  logic [fadd_pkg::MantW:0]   norm;
  logic signed [9:0]          e;
  logic [fadd_pkg::WordW-1:0] res_nxt, res_r;
  logic                       valid_r;

  // magnitude add, leading-one search, normalize
  always_comb begin
    r = item.eff_sub ? ({1'b0, item.m_big} - {1'b0, item.m_small})
                     : ({1'b0, item.m_big} + {1'b0, item.m_small});
    p = '0;
    for (int i = 0; i <= fadd_pkg::MantW; i++) begin
      if (r[i]) p = 5'(i);
    end
    norm = (p >= 5'd23) ? (r >> (p - 5'd23)) : (r << (5'd23 - p));
    e = $signed({2'b00, item.e_big}) + $signed({5'b0, p}) - 10'sd23;
    if (item.bypass) begin
      res_nxt = item.bypass_val;
    end else if (r == '0) begin
      res_nxt = '0;
    end else if (e >= 10'sd255) begin
      res_nxt = {item.sign_big, fadd_pkg::ExpMax, 23'b0};
    end else if (e <= 10'sd0) begin
      res_nxt = {item.sign_big, 31'b0};
    end else begin
      res_nxt = {item.sign_big, e[7:0], norm[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item_valid;
    end
    res_r <= res_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_bits = res_r;

endmodule

// File: sv/float32_add_subtract_core.sv
// ----------------------------------------------------------------------------
// float32_add_subtract_core: single-precision add/subtract, truncating
// Front part classifies and aligns, a short queue decouples, back part adds,
// normalizes and packs.
// ----------------------------------------------------------------------------
// channel  | ports                                      | handshake
// input    | in_operand_a, in_operand_b, in_operation    | start & !busy
// result   | out_result_bits                            | out_strobe, 1 cycle
//
// One operand pair per cycle; each result passes through the front register,
// a queue entry and the back register on its way out.
// busy stays low: the back part never stalls, so the queue never fills.
// Synchronous active-low reset clears valid flags and queue pointers.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module float32_add_subtract_core #(
  parameter int QueueDepth = fadd_pkg::QueueDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [fadd_pkg::WordW-1:0]  in_operand_a,
  input  logic [fadd_pkg::WordW-1:0]  in_operand_b,
  input  logic                        in_operation,
  output logic                        out_strobe,
  output logic [fadd_pkg::WordW-1:0]  out_result_bits
);

  logic                 f_valid, q_ne;
  fadd_pkg::fadd_item_t f_item, q_head;

  assign busy = 1'b0;

  fadd_front u_front (
    .clk, .rst_n,
    .in_beat(start && !busy),
    .in_operand_a, .in_operand_b, .in_operation,
    .item_valid(f_valid), .item(f_item)
  );

  fadd_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .push(f_valid), .push_item(f_item),
    .pop(q_ne), .not_empty(q_ne), .head(q_head)
  );

  fadd_back u_back (
    .clk, .rst_n,
    .item_valid(q_ne), .item(q_head),
    .out_valid(out_strobe), .out_result_bits
  );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the float32 add/subtract core
// Drives operand pairs through the start/busy command port, predicts each
// truncated sum or difference in a local model and compares every strobed
// result against the oldest prediction. Directed corner rows come first,
// then random pairs biased toward close exponents and special encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  typedef enum logic {OpAdd = 1'b0, OpSub = 1'b1} fadd_op_t;

  // One directed stimulus row; has_want marks rows with a typed-in result
  typedef struct {
    logic [fadd_pkg::WordW-1:0] a;
    logic [fadd_pkg::WordW-1:0] b;
    fadd_op_t                   op;
    logic                       has_want;
    logic [fadd_pkg::WordW-1:0] want;
  } fadd_row_t;

  localparam int NumRandom  = 950;
  localparam int IdleLimit  = 2000;
  localparam int DrainWait  = 8;
  localparam logic [fadd_pkg::WordW-1:0] SignBit = 32'h8000_0000;
  localparam logic [fadd_pkg::WordW-1:0] PosInf  = 32'h7F80_0000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [fadd_pkg::WordW-1:0] in_operand_a = '0;
  logic [fadd_pkg::WordW-1:0] in_operand_b = '0;
  logic                       in_operation = 1'b0;
  logic                       out_strobe;
  logic [fadd_pkg::WordW-1:0] out_result_bits;

  logic [fadd_pkg::WordW-1:0] sum_queue[$];
  int                         fail_count = 0;
  int                         idle_cycles = 0;
  logic                       no_gaps = 1'b0;

  float32_add_subtract_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .in_operation(in_operation), .out_strobe(out_strobe),
    .out_result_bits(out_result_bits)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Truncating single-precision add/subtract
  function automatic logic [fadd_pkg::WordW-1:0] float_sum(
      logic [fadd_pkg::WordW-1:0] a,
      logic [fadd_pkg::WordW-1:0] b,
      fadd_op_t op);
    logic [fadd_pkg::WordW-1:0] big, little;
    logic [fadd_pkg::MantW-1:0] m_big, m_little;
    logic [fadd_pkg::MantW:0]   r;
    logic [fadd_pkg::FracW-1:0] frac;
    int                         d, p, e;
    if (op == OpSub) b = b ^ SignBit;
    if (a[30:23] == 0 && b[30:23] == 0) return '0;
    if (a[30:23] == 0) return b;
    if (b[30:23] == 0) return a;
    if (a[30:0] >= b[30:0]) begin
      big = a; little = b;
    end else begin
      big = b; little = a;
    end
    m_big    = {1'b1, big[22:0]};
    m_little = {1'b1, little[22:0]};
    d = int'(big[30:23]) - int'(little[30:23]);
    m_little = (d >= 24) ? '0 : m_little >> d;
    if (big[31] == little[31]) r = {1'b0, m_big} + {1'b0, m_little};
    else r = {1'b0, m_big} - {1'b0, m_little};
    if (r == 0) return '0;
    p = 24;
    while (p > 0 && !r[p]) p--;
    e = int'(big[30:23]) + p - 23;
    frac = (p >= 23) ? fadd_pkg::FracW'(r >> (p - 23))
                     : fadd_pkg::FracW'(r << (23 - p));
    if (e >= 255) return {big[31], 31'h7F80_0000};
    if (e <= 0) return {big[31], 31'h0};
    return {big[31], 8'(e), frac};
  endfunction

  // Random operand: mostly ordinary numbers, some zero, subnormal, Inf/NaN
  function automatic logic [fadd_pkg::WordW-1:0] rand_operand(
      logic [fadd_pkg::ExpW-1:0] near_exp);
    logic [fadd_pkg::WordW-1:0] v;
    int                         pick;
    v = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 5) v[30:23] = '0;
    else if (pick < 9) v[30:23] = fadd_pkg::ExpMax;
    else if (pick < 13) v[30:23] = fadd_pkg::ExpMax - 8'd1;
    else if (pick < 17) v[30:23] = 8'd1;
    else if (pick < 75)
      v[30:23] = near_exp + fadd_pkg::ExpW'($urandom_range(0, 6)) - 8'd3;
    return v;
  endfunction

  // Send one beat and record its expected result
  task automatic send_beat(logic [fadd_pkg::WordW-1:0] a,
                           logic [fadd_pkg::WordW-1:0] b, fadd_op_t op,
                           logic [fadd_pkg::WordW-1:0] want);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operation <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    sum_queue.push_back(want);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (sum_queue.size() == 0) begin
        $error("result_bits: unexpected beat, actual %h", out_result_bits);
        fail_count++;
      end else begin
        if (out_result_bits !== sum_queue[0]) begin
          $error("result_bits: expected %h actual %h", sum_queue[0], out_result_bits);
          fail_count++;
        end
        void'(sum_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles with no accepted beat and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    fadd_row_t                  rows[$];
    fadd_row_t                  row;
    logic [fadd_pkg::WordW-1:0] a, b;
    logic [fadd_pkg::ExpW-1:0]  ex;
    fadd_op_t                   op;
    rows = '{
      '{32'h0000_0000, 32'h0000_0000, OpAdd, 1'b1, 32'h0000_0000},
      '{32'h8000_0000, 32'h8000_0000, OpSub, 1'b1, 32'h0000_0000},
      '{32'h0000_0000, 32'h3F80_0000, OpSub, 1'b1, 32'hBF80_0000},
      '{32'h4040_0000, 32'h0000_0001, OpAdd, 1'b1, 32'h4040_0000},
      '{32'h007F_FFFF, 32'h8040_0000, OpAdd, 1'b1, 32'h0000_0000},
      '{32'h3F80_0000, 32'h3F80_0000, OpSub, 1'b1, 32'h0000_0000},
      '{32'hC120_0000, 32'hC120_0000, OpSub, 1'b1, 32'h0000_0000},
      '{32'h3F80_0000, 32'h3F80_0000, OpAdd, 1'b1, 32'h4000_0000},
      '{32'h7F7F_FFFF, 32'h7F7F_FFFF, OpAdd, 1'b1, PosInf},
      '{32'hFF7F_FFFF, 32'h7F7F_FFFF, OpSub, 1'b1, 32'hFF80_0000},
      '{PosInf,        32'h3F80_0000, OpAdd, 1'b1, PosInf},
      '{32'h7FC0_0000, 32'hFFC0_0000, OpSub, 1'b0, '0},
      '{32'h4B80_0000, 32'h3F80_0000, OpAdd, 1'b1, 32'h4B80_0000},
      '{32'h3F80_0000, 32'hCC00_0000, OpAdd, 1'b1, 32'hCC00_0000},
      '{32'h0080_0001, 32'h0080_0000, OpSub, 1'b1, 32'h0000_0000},
      '{32'h0100_0000, 32'h00FF_FFFF, OpSub, 1'b0, '0},
      '{32'h3F80_0000, 32'hBF7F_FFFF, OpAdd, 1'b0, '0},
      '{32'h4049_0FDB, 32'h402D_F854, OpAdd, 1'b0, '0},
      '{32'h4049_0FDB, 32'h402D_F854, OpSub, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, OpAdd, 1'b0, '0},
      '{32'h3F80_0000, 32'h4B7F_FFFF, OpSub, 1'b0, '0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; typed-in results cross-check the predictor too
    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_want && float_sum(row.a, row.b, row.op) !== row.want) begin
        $error("result_bits: row %0d expected %h actual %h", i, row.want,
               float_sum(row.a, row.b, row.op));
        fail_count++;
      end
      send_beat(row.a, row.b, row.op,
                row.has_want ? row.want : float_sum(row.a, row.b, row.op));
    end

    // Random pairs, with a gap-free stretch in the middle
    for (int n = 0; n < NumRandom; n++) begin
      no_gaps = (n >= 300 && n < 450);
      ex = fadd_pkg::ExpW'($urandom_range(1, 254));
      a  = rand_operand(ex);
      b  = rand_operand(ex);
      if ($urandom_range(0, 9) == 0) b = {$urandom_range(0, 1) ? a[31] : ~a[31], a[30:0]};
      op = fadd_op_t'($urandom_range(0, 1));
      send_beat(a, b, op, float_sum(a, b, op));
    end
    start <= 1'b0;

    while (sum_queue.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// File: filelist.f
sv/fadd_pkg.sv
sv/fadd_front.sv
sv/fadd_queue.sv
sv/fadd_back.sv
sv/float32_add_subtract_core.sv
verif/tb.sv
